### rtl/erfp_pkg.sv
// Shared types and constants for the escaped response frame parser.
package erfp_pkg;

   // Field widths
   localparam int TickWidth  = 24;
   localparam int LenWidth   = 16;
   localparam int ByteWidth  = 8;
   localparam int CsrWidth   = 24;
   localparam int CsrIdxWidth = 2;

   // Response queue depth (room for two results from one request plus slack)
   localparam int RspDepth = 4;

   // Register reset values
   localparam logic [TickWidth-1:0] TimeoutReset = 24'd2000000;
   localparam logic [LenWidth-1:0]  MaxPayReset  = 16'd65535;
   localparam logic [LenWidth-1:0]  SkipReset    = 16'd4096;
   localparam logic [TickWidth-1:0] TickMax      = 24'hFFFFFF;

   // Protocol bytes
   localparam logic [ByteWidth-1:0] MarkerByte   = 8'h06;
   localparam logic [ByteWidth-1:0] EscapeByte   = 8'h1A;
   localparam logic [ByteWidth-1:0] EscapeOffset = 8'h20;
   localparam logic [ByteWidth-1:0] HostOkByte   = 8'h2B;
   localparam logic [ByteWidth-1:0] NewlineByte  = 8'h0A;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TIMEOUT  = 2'd0,
      CSR_MAX_PAY  = 2'd1,
      CSR_SKIP_LIM = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_HOST    = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_BADHEX  = 3'd3,
      ST_NONL    = 3'd4,
      ST_NOMARK  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HUNT    = 3'd1,
      PH_STATUS  = 3'd2,
      PH_DIGITS  = 3'd3,
      PH_NEWLINE = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_ESCAPED = 3'd6
   } phase_type;

   typedef struct packed {
      logic [TickWidth-1:0] timeout_ticks;
      logic [LenWidth-1:0]  max_payload;
      logic [LenWidth-1:0]  skip_limit;
   } cfg_type;

   typedef struct packed {
      logic                 is_done;
      logic [ByteWidth-1:0] payload_byte;
      logic [LenWidth-1:0]  byte_index;
      status_type           status;
      logic [LenWidth-1:0]  length;
      logic                 last;
   } rsp_type;

endpackage

### rtl/escaped_response_frame_parser_top.sv
// Escaped response frame parser: top level with request register and CSRs.
//
// Requests (req_kind, req_data_byte) arrive on a valid/ready channel: a start
// request arms the parser, byte requests feed the serial stream and tick
// requests advance the inter-byte timeout. Results leave on the rsp_ channel,
// one per accepted handshake: decoded payload bytes, then one completion
// report with status and clamped length. rsp_last marks the final result of
// a request; one request yields at most two results.
// A request in the request register is decoded once the result queue has room
// for two results; its results are registered in the queue before rsp_valid.
// Throughput: one request per cycle, set by the combinational decode between
// the request register and the four-entry result queue; the queue must have
// two free slots for the held request to be decoded.
// CSRs: csr_wr_en/csr_index/csr_wdata write timeout_ticks (0), max_payload (1)
// and skip_limit (2); only while the block is idle, a user rule not enforced.
// Reset: synchronous; the parser goes idle, the queue empties and the
// registers take their defaults. Once a stalled receiver leaves the queue
// without room for two results, req_ready drops until results are taken.
module escaped_response_frame_parser_top #(
   parameter int RSP_DEPTH = erfp_pkg::RspDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_done,
   output logic [7:0]                      rsp_payload_byte,
   output logic [15:0]                     rsp_byte_index,
   output logic [2:0]                      rsp_status,
   output logic [15:0]                     rsp_length,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [erfp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [erfp_pkg::CsrWidth-1:0]   csr_wdata
);
   import erfp_pkg::*;

   cfg_type     cfg_ff;
   logic        in_valid_ff, in_valid_in;
   kind_type    in_kind_ff;
   logic [7:0]  in_byte_ff;
   logic        room2, advance;
   rsp_type     res0, res1, rsp;
   logic [1:0]  res_cnt;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TimeoutReset;
         cfg_ff.max_payload   <= MaxPayReset;
         cfg_ff.skip_limit    <= SkipReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT:  cfg_ff.timeout_ticks <= csr_wdata;
            CSR_MAX_PAY:  cfg_ff.max_payload   <= csr_wdata[LenWidth-1:0];
            CSR_SKIP_LIM: cfg_ff.skip_limit    <= csr_wdata[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Request register: drain when the queue has room for two results
   assign advance     = in_valid_ff && room2;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= kind_type'(req_kind);
         in_byte_ff <= req_data_byte;
      end
   end

   erfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .proc_en   (advance),
      .kind      (in_kind_ff),
      .data_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .res0      (res0),
      .res1      (res1),
      .res_cnt   (res_cnt)
   );

   erfp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_data0 (res0),
      .wr_data1 (res1),
      .wr_cnt   (res_cnt),
      .room2    (room2),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (rsp)
   );

   assign rsp_is_done      = rsp.is_done;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_index   = rsp.byte_index;
   assign rsp_status       = rsp.status;
   assign rsp_length       = rsp.length;
   assign rsp_last         = rsp.last;

endmodule

### rtl/erfp_core.sv
// Frame parser state and per-request decode; produces up to two results.
module erfp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 proc_en,
   input  erfp_pkg::kind_type   kind,
   input  logic [7:0]           data_byte,
   input  erfp_pkg::cfg_type    cfg,
   output erfp_pkg::rsp_type    res0,
   output erfp_pkg::rsp_type    res1,
   output logic [1:0]           res_cnt
);
   import erfp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [TickWidth-1:0] tick_ff, tick_in;
   logic [LenWidth-1:0]  skip_ff, skip_in;
   logic                 host_ok_ff, host_ok_in;
   logic [1:0]           digit_ff, digit_in;
   logic [LenWidth-1:0]  flen_ff, flen_in;
   logic [LenWidth-1:0]  pcount_ff, pcount_in;

   logic                 emit_pay, emit_done;
   status_type           done_st;
   logic [ByteWidth-1:0] pay_val;
   logic [LenWidth-1:0]  skip_lim;
   logic [LenWidth-1:0]  clamp_len;
   logic [3:0]           hex_nib;
   logic                 hex_ok;
   rsp_type              pay_res, done_res;

   // Decode one hex digit, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = 4'd0;
      if (data_byte inside {[8'h30:8'h39]}) begin
         hex_nib = data_byte[3:0];
      end else if (data_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_nib = data_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign skip_lim  = (cfg.skip_limit == '0) ? 16'd1 : cfg.skip_limit;
   assign clamp_len = (flen_ff < cfg.max_payload) ? flen_ff : cfg.max_payload;

   // Next state and result selection
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      skip_in    = skip_ff;
      host_ok_in = host_ok_ff;
      digit_in   = digit_ff;
      flen_in    = flen_ff;
      pcount_in  = pcount_ff;
      emit_pay   = 1'b0;
      emit_done  = 1'b0;
      done_st    = ST_OK;
      pay_val    = (phase_ff == PH_ESCAPED) ? data_byte - EscapeOffset : data_byte;

      if (proc_en) begin
         case (kind)
            KIND_START: begin
               phase_in   = PH_HUNT;
               tick_in    = '0;
               skip_in    = '0;
               host_ok_in = 1'b0;
               digit_in   = '0;
               flen_in    = '0;
               pcount_in  = '0;
            end
            KIND_BYTE: begin
               if (phase_ff != PH_IDLE) begin
                  tick_in = '0;
                  case (phase_ff)
                     PH_HUNT: begin
                        if (data_byte == MarkerByte) begin
                           phase_in = PH_STATUS;
                        end else begin
                           skip_in = skip_ff + 16'd1;
                           if (skip_in >= skip_lim) begin
                              emit_done = 1'b1;
                              done_st   = ST_NOMARK;
                           end
                        end
                     end
                     PH_STATUS: begin
                        host_ok_in = (data_byte == HostOkByte);
                        digit_in   = '0;
                        flen_in    = '0;
                        phase_in   = PH_DIGITS;
                     end
                     PH_DIGITS: begin
                        if (!hex_ok) begin
                           emit_done = 1'b1;
                           done_st   = ST_BADHEX;
                        end else begin
                           flen_in = {flen_ff[LenWidth-5:0], hex_nib};
                           if (digit_ff == 2'd3) begin
                              digit_in = '0;
                              phase_in = PH_NEWLINE;
                           end else begin
                              digit_in = digit_ff + 2'd1;
                           end
                        end
                     end
                     PH_NEWLINE: begin
                        if (data_byte != NewlineByte) begin
                           emit_done = 1'b1;
                           done_st   = ST_NONL;
                        end else begin
                           pcount_in = '0;
                           if (flen_ff == '0) begin
                              emit_done = 1'b1;
                              done_st   = host_ok_ff ? ST_OK : ST_HOST;
                           end else begin
                              phase_in = PH_PAYLOAD;
                           end
                        end
                     end
                     PH_PAYLOAD, PH_ESCAPED: begin
                        if (phase_ff == PH_PAYLOAD && data_byte == EscapeByte) begin
                           phase_in = PH_ESCAPED;
                        end else begin
                           emit_pay  = (pcount_ff < cfg.max_payload);
                           pcount_in = pcount_ff + 16'd1;
                           phase_in  = PH_PAYLOAD;
                           if (pcount_in >= flen_ff) begin
                              emit_done = 1'b1;
                              done_st   = host_ok_ff ? ST_OK : ST_HOST;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  tick_in = (tick_ff != TickMax) ? tick_ff + 24'd1 : tick_ff;
                  if (tick_in > cfg.timeout_ticks) begin
                     emit_done = 1'b1;
                     done_st   = ST_TIMEOUT;
                  end
               end
            end
            default: ;
         endcase
         // A completion always returns the parser to idle
         if (emit_done) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Build the two candidate results and pack them in order
   always_comb begin
      pay_res              = '0;
      pay_res.is_done      = 1'b0;
      pay_res.payload_byte = pay_val;
      pay_res.byte_index   = pcount_ff;
      pay_res.status       = ST_OK;
      pay_res.last         = !emit_done;

      done_res             = '0;
      done_res.is_done     = 1'b1;
      done_res.status      = done_st;
      done_res.length      = (done_st == ST_OK || done_st == ST_HOST) ? clamp_len : '0;
      done_res.last        = 1'b1;

      res0    = emit_pay ? pay_res : done_res;
      res1    = done_res;
      res_cnt = {1'b0, emit_pay} + {1'b0, emit_done};
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         skip_ff    <= '0;
         host_ok_ff <= 1'b0;
         digit_ff   <= '0;
         flen_ff    <= '0;
         pcount_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         skip_ff    <= skip_in;
         host_ok_ff <= host_ok_in;
         digit_ff   <= digit_in;
         flen_ff    <= flen_in;
         pcount_ff  <= pcount_in;
      end
   end

endmodule

### rtl/erfp_rsp_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per ready cycle.
module erfp_rsp_fifo #(
   parameter int DEPTH = erfp_pkg::RspDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  erfp_pkg::rsp_type wr_data0,
   input  erfp_pkg::rsp_type wr_data1,
   input  logic [1:0]        wr_cnt,
   output logic              room2,
   output logic              rd_valid,
   input  logic              rd_ready,
   output erfp_pkg::rsp_type rd_data
);
   import erfp_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

   rsp_type           mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr1;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
   endfunction

   assign pop      = rd_valid && rd_ready;
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign room2    = (cnt_ff <= CntW'(DEPTH - 2));
   assign wr_ptr1  = ptr_inc(wr_ptr_ff);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (wr_cnt)
         2'd1:    wr_ptr_in = wr_ptr1;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr1);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(wr_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store results in arrival order
   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_cnt == 2'd2) begin
         mem_ff[wr_ptr1] <= wr_data1;
      end
   end

endmodule

### rtl/erfp_checker.sv
// Port-level checks for the escaped response frame parser, bound to the top.
module erfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_done,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_byte_index,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_length,
   input logic        rsp_last
);
   import erfp_pkg::*;

   // Queue is empty and requests are taken right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result valid or request blocked after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_done)
         && $stable(rsp_payload_byte) && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // A completion report ends its request
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_done |-> rsp_last)
      else $error("completion without last");

   // Payload results carry no status or length
   a_pay_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_done |-> rsp_status == ST_OK && rsp_length == 16'd0)
      else $error("payload result with status or length");

   // Failure reports carry zero length
   a_fail_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_done && rsp_status != ST_OK && rsp_status != ST_HOST
         |-> rsp_length == 16'd0)
      else $error("failure report with nonzero length");

endmodule

bind escaped_response_frame_parser_top erfp_checker u_erfp_checker (.*);
